### src/mfbr_pkg.sv
// shared types and constants for the mono frame block repacker
// no dependencies; imported by mfbr_window_calc and mono_frame_block_repacker
package mfbr_pkg;

  localparam int PANEL_WIDTH_DEF  = 400;
  localparam int PANEL_HEIGHT_DEF = 300;
  localparam int COLUMN_GROUP_DEF = 8;

  // widths sized for the full parameter range
  localparam int COL_W = 10;
  localparam int ROW_W = 8;
  localparam int Q_SHIFT = 16;

  localparam logic [5:0] COL_ADDR_BASE = 6'h12;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_OPEN = 2'd1;
  localparam logic [1:0] OP_EMIT = 2'd2;

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [13:0] src_address;
    logic [7:0]  src_byte;
    logic [7:0]  block_x;
    logic [6:0]  block_y;
    logic [7:0]  block_w;
    logic [6:0]  block_h;
  } cmd_t;

  typedef struct packed {
    logic       result_kind;
    logic [5:0] col_addr_first;
    logic [5:0] col_addr_final;
    logic [6:0] page_first;
    logic [6:0] page_final;
    logic       window_empty;
    logic [7:0] packed_byte;
    logic       last_byte;
  } result_t;

  typedef struct packed {
    logic             empty;
    logic [7:0]       col_start;
    logic [COL_W-1:0] col_count;
    logic [6:0]       row_start;
    logic [ROW_W-1:0] row_count;
    logic [5:0]       col_addr_first;
    logic [5:0]       col_addr_final;
    logic [6:0]       page_first;
    logic [6:0]       page_final;
  } win_info_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_EMIT_ADDR,
    ST_EMIT_READ,
    ST_EMIT_LAST
  } state_t;

endpackage

### src/mfbr_frame_mem.sv
// single-port source frame memory, one byte per entry, registered read
// depends on nothing; instantiated by mono_frame_block_repacker
module mfbr_frame_mem #(
  parameter int DEPTH = 15000,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### src/mfbr_window_calc.sv
// three-stage window setup: quotient estimate, quotient correction, clamping and address report
// depends on mfbr_pkg; instantiated by mono_frame_block_repacker
module mfbr_window_calc #(
  parameter int PANEL_WIDTH  = mfbr_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mfbr_pkg::PANEL_HEIGHT_DEF,
  parameter int COLUMN_GROUP = mfbr_pkg::COLUMN_GROUP_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  mfbr_pkg::cmd_t     cmd,
  output logic               valid,
  output mfbr_pkg::win_info_t info
);
  import mfbr_pkg::*;

  localparam int BLOCK_COLS = PANEL_WIDTH / 2;
  localparam int BLOCK_ROWS = PANEL_HEIGHT / 4;
  localparam int RECIP      = (1 << Q_SHIFT) / COLUMN_GROUP;
  localparam int LAST_GRP   = (BLOCK_COLS - 1) / COLUMN_GROUP;

  // stage 1: quotient estimates
  logic        s1_valid;
  logic [7:0]  s1_bx;
  logic [10:0] s1_vhi;
  logic [6:0]  s1_by;
  logic [7:0]  s1_row_hi;
  logic [7:0]  s1_qlo;
  logic [10:0] s1_qhi;

  // stage 2: corrected quotients
  logic        s2_valid;
  logic [7:0]  s2_qlo;
  logic [10:0] s2_qhi;
  logic [6:0]  s2_by;
  logic [7:0]  s2_row_hi;

  logic [10:0] vhi;
  logic [27:0] prod_lo;
  logic [27:0] prod_hi;
  logic [15:0] rem_lo;
  logic [15:0] rem_hi;
  logic        fix_lo;
  logic        fix_hi;

  logic [15:0] col_lo;
  logic [15:0] col_raw;
  logic [15:0] col_hi;
  logic [8:0]  row_hi_c;
  logic        empty;
  logic [10:0] grp_final;

  assign vhi     = 11'(cmd.block_x) + 11'(cmd.block_w) + 11'(COLUMN_GROUP - 1);
  assign prod_lo = 28'(cmd.block_x) * 28'(RECIP);
  assign prod_hi = 28'(vhi) * 28'(RECIP);

  always_ff @(posedge clk) begin
    s1_bx     <= cmd.block_x;
    s1_vhi    <= vhi;
    s1_by     <= cmd.block_y;
    s1_row_hi <= 8'(cmd.block_y) + 8'(cmd.block_h);
    s1_qlo    <= 8'(prod_lo >> Q_SHIFT);
    s1_qhi    <= 11'(prod_hi >> Q_SHIFT);
  end

  assign rem_lo = 16'(s1_bx) - 16'(s1_qlo) * 16'(COLUMN_GROUP);
  assign rem_hi = 16'(s1_vhi) - 16'(s1_qhi) * 16'(COLUMN_GROUP);
  assign fix_lo = rem_lo >= 16'(COLUMN_GROUP);
  assign fix_hi = rem_hi >= 16'(COLUMN_GROUP);

  always_ff @(posedge clk) begin
    s2_qlo    <= s1_qlo + 8'(fix_lo);
    s2_qhi    <= s1_qhi + 11'(fix_hi);
    s2_by     <= s1_by;
    s2_row_hi <= s1_row_hi;
  end

  assign col_lo   = 16'(s2_qlo) * 16'(COLUMN_GROUP);
  assign col_raw  = 16'(s2_qhi) * 16'(COLUMN_GROUP);
  assign col_hi   = (col_raw > 16'(BLOCK_COLS)) ? 16'(BLOCK_COLS) : col_raw;
  assign row_hi_c = (9'(s2_row_hi) > 9'(BLOCK_ROWS)) ? 9'(BLOCK_ROWS) : 9'(s2_row_hi);
  assign empty    = (col_hi <= col_lo) || (row_hi_c <= 9'(s2_by));
  assign grp_final = (col_raw > 16'(BLOCK_COLS)) ? 11'(LAST_GRP) : s2_qhi - 11'd1;

  always_ff @(posedge clk) begin
    info.empty     <= empty;
    info.col_start <= s2_qlo * 8'(COLUMN_GROUP);
    info.col_count <= COL_W'(col_hi - col_lo);
    info.row_start <= s2_by;
    info.row_count <= ROW_W'(row_hi_c - 9'(s2_by));
    if (empty) begin
      info.col_addr_first <= '0;
      info.col_addr_final <= '0;
      info.page_first     <= '0;
      info.page_final     <= '0;
    end else begin
      info.col_addr_first <= COL_ADDR_BASE + 6'(s2_qlo);
      info.col_addr_final <= COL_ADDR_BASE + 6'(grp_final);
      info.page_first     <= s2_by;
      info.page_final     <= 7'(row_hi_c - 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      valid    <= 1'b0;
    end else begin
      s1_valid <= go;
      s2_valid <= s1_valid;
      valid    <= s2_valid;
    end
  end

endmodule

### src/mono_frame_block_repacker.sv
// top level: command sequencer, run state and pixel pair gather
// depends on mfbr_pkg, mfbr_frame_mem and mfbr_window_calc
//
//  channel  | ports                 | transaction
//  ---------+-----------------------+-------------------------------------
//  command  | start, busy, cmd      | start high and busy low at clk edge
//  result   | done, result          | done high for one cycle, no stall
//
// load: busy stays low. open window: the command passes through the setup
// pipeline, and the report shows in the cycle after it leaves. emit: an address
// step, four serial reads of the single-port frame memory, then a merge step.
// rst is synchronous; the frame memory is not cleared and reads undefined
// until loaded. the receiver cannot stall: each result shows for one cycle.
module mono_frame_block_repacker #(
  parameter int PANEL_WIDTH  = mfbr_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = mfbr_pkg::PANEL_HEIGHT_DEF,
  parameter int COLUMN_GROUP = mfbr_pkg::COLUMN_GROUP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mfbr_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output mfbr_pkg::result_t result
);
  import mfbr_pkg::*;

  localparam int ROW_STRIDE  = (PANEL_WIDTH + 7) / 8;
  localparam int FRAME_BYTES = ROW_STRIDE * PANEL_HEIGHT;
  localparam int AW          = $clog2(FRAME_BYTES);
  localparam int YW          = $clog2(PANEL_HEIGHT);
  localparam int BW          = COL_W - 2;

  state_t state;
  state_t state_next;

  logic             run_active;
  logic [7:0]       win_col_start;
  logic [COL_W-1:0] win_col_count;
  logic [6:0]       win_row_start;
  logic [ROW_W-1:0] win_row_count;
  logic [COL_W-1:0] run_col;
  logic [ROW_W-1:0] run_row;

  logic [YW-1:0]    y0;
  logic [BW-1:0]    byte_col;
  logic [1:0]       pair_sel;
  logic             last_flag;
  logic [AW-1:0]    rd_addr;
  logic [1:0]       rd_cnt;
  logic [5:0]       acc;

  logic             accept;
  logic             ld_ok;
  logic [31:0]      ld_addr32;
  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_addr;
  logic [7:0]       mem_rdata;
  logic             win_go;
  logic             win_valid;
  win_info_t        win_info;

  logic [COL_W-1:0] bcol;
  logic [ROW_W-1:0] brow;
  logic [ROW_W-1:0] row_inc;
  logic [COL_W-1:0] col_inc;
  logic             row_wrap;
  logic             col_wrap;
  logic [1:0]       pair;

  assign accept    = start && !busy;
  assign ld_addr32 = 32'(cmd.src_address);
  assign ld_ok     = ld_addr32 < 32'(FRAME_BYTES);
  assign mem_addr  = mem_we ? ld_addr32[AW-1:0] : rd_addr;

  assign bcol     = COL_W'(win_col_start) + run_col;
  assign brow     = ROW_W'(win_row_start) + run_row;
  assign row_inc  = run_row + ROW_W'(1);
  assign col_inc  = run_col + COL_W'(1);
  assign row_wrap = row_inc >= win_row_count;
  assign col_wrap = col_inc >= win_col_count;

  always_comb begin
    case (pair_sel)
      2'd0:    pair = mem_rdata[7:6];
      2'd1:    pair = mem_rdata[5:4];
      2'd2:    pair = mem_rdata[3:2];
      default: pair = mem_rdata[1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    win_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (cmd.opcode)
            OP_LOAD: mem_we = ld_ok;
            OP_OPEN: begin
              win_go     = 1'b1;
              state_next = ST_WIN;
            end
            OP_EMIT: if (run_active) state_next = ST_EMIT_ADDR;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_WIN: if (win_valid) state_next = ST_IDLE;
      ST_EMIT_ADDR: state_next = ST_EMIT_READ;
      ST_EMIT_READ: begin
        mem_re = 1'b1;
        if (rd_cnt == 2'd3) state_next = ST_EMIT_LAST;
      end
      ST_EMIT_LAST: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // run state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active    <= 1'b0;
      win_col_start <= '0;
      win_col_count <= '0;
      win_row_start <= '0;
      win_row_count <= '0;
      run_col       <= '0;
      run_row       <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == ST_IDLE && accept && cmd.opcode == OP_EMIT && run_active) begin
        if (row_wrap) begin
          run_row <= '0;
          if (col_wrap) begin
            run_col    <= '0;
            run_active <= 1'b0;
          end else begin
            run_col <= col_inc;
          end
        end else begin
          run_row <= row_inc;
        end
      end
      if (state == ST_WIN && win_valid) begin
        done <= 1'b1;
        if (win_info.empty) begin
          run_active <= 1'b0;
        end else begin
          run_active    <= 1'b1;
          win_col_start <= win_info.col_start;
          win_col_count <= win_info.col_count;
          win_row_start <= win_info.row_start;
          win_row_count <= win_info.row_count;
          run_col       <= '0;
          run_row       <= '0;
        end
      end
      if (state == ST_EMIT_LAST) begin
        done <= 1'b1;
      end
    end
  end

  // emit datapath and result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      y0        <= YW'(32'(PANEL_HEIGHT - 1) - (32'(brow) << 2));
      byte_col  <= BW'(bcol >> 2);
      pair_sel  <= bcol[1:0];
      last_flag <= row_wrap && col_wrap;
    end
    if (state == ST_EMIT_ADDR) begin
      rd_addr <= AW'(32'(y0) * 32'(ROW_STRIDE) + 32'(byte_col));
      rd_cnt  <= '0;
    end
    if (state == ST_EMIT_READ) begin
      rd_addr <= rd_addr - AW'(ROW_STRIDE);
      rd_cnt  <= rd_cnt + 2'd1;
      if (rd_cnt != 2'd0) begin
        acc <= {acc[3:0], pair};
      end
    end
    if (state == ST_WIN && win_valid) begin
      result.result_kind    <= KIND_WINDOW;
      result.col_addr_first <= win_info.col_addr_first;
      result.col_addr_final <= win_info.col_addr_final;
      result.page_first     <= win_info.page_first;
      result.page_final     <= win_info.page_final;
      result.window_empty   <= win_info.empty;
      result.packed_byte    <= '0;
      result.last_byte      <= 1'b0;
    end
    if (state == ST_EMIT_LAST) begin
      result.result_kind    <= KIND_PIXEL;
      result.col_addr_first <= '0;
      result.col_addr_final <= '0;
      result.page_first     <= '0;
      result.page_final     <= '0;
      result.window_empty   <= 1'b0;
      result.packed_byte    <= {acc, pair};
      result.last_byte      <= last_flag;
    end
  end

  mfbr_frame_mem #(
    .DEPTH(FRAME_BYTES),
    .AW   (AW)
  ) u_frame_mem (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(cmd.src_byte),
    .rdata(mem_rdata)
  );

  mfbr_window_calc #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT),
    .COLUMN_GROUP(COLUMN_GROUP)
  ) u_window_calc (
    .clk  (clk),
    .rst  (rst),
    .go   (win_go),
    .cmd  (cmd),
    .valid(win_valid),
    .info (win_info)
  );

endmodule
